/* src/bdpc_pkg.sv */
// Shared types and constants for the button debounce and press classifier.
// Holds the per-button state entry, the configuration bundle and the codes.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bdpc_pkg;

    // Field widths fixed by the interface
    localparam int TIME_W      = 32;
    localparam int CNT_W       = 4;
    localparam int HOLD_W      = 16;
    localparam int MASK_W      = 2;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_LONG_HOLD = 3'd1,
        CFG_VLONG     = 3'd2,
        CFG_MIN_SHORT = 3'd3,
        CFG_MASK      = 3'd4
    } cfg_idx_t;

    // Event kinds reported on the output
    typedef enum logic [KIND_W-1:0] {
        EV_SHORT = 2'd0,
        EV_LONG  = 2'd1,
        EV_VLONG = 2'd2
    } event_kind_t;

    // Reset values of the configuration registers
    localparam logic [CNT_W-1:0]  DEBOUNCE_RST  = 4'd5;
    localparam logic [HOLD_W-1:0] LONG_RST      = 16'd2000;
    localparam logic [HOLD_W-1:0] VLONG_RST     = 16'd3000;
    localparam logic [HOLD_W-1:0] MIN_SHORT_RST = 16'd50;
    localparam logic [MASK_W-1:0] MASK_RST      = 2'd2;

    // Configuration bundle seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]  settle_count;
        logic [HOLD_W-1:0] long_hold_ms;
        logic [HOLD_W-1:0] very_long_hold_ms;
        logic [HOLD_W-1:0] min_short_ms;
        logic [MASK_W-1:0] vlong_as_short_mask;
    } cfg_t;

    // One button's state as kept in the state memory
    typedef struct packed {
        logic              stable_pressed;
        logic              previous_raw;
        logic [CNT_W-1:0]  run_count;
        logic [TIME_W-1:0] press_time;
        logic              long_done;
        logic              very_long_done;
    } btn_entry_t;

endpackage

/* src/bdpc_cfg.sv */
// Configuration register file of the press classifier.
// Decodes indexed writes into the thresholds, debounce count and mask.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output bdpc_pkg::cfg_t                   cfg
);
    import bdpc_pkg::*;

    cfg_t cfg_reg;

    // Always take a write beat
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index; drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_count        <= DEBOUNCE_RST;
            cfg_reg.long_hold_ms        <= LONG_RST;
            cfg_reg.very_long_hold_ms   <= VLONG_RST;
            cfg_reg.min_short_ms        <= MIN_SHORT_RST;
            cfg_reg.vlong_as_short_mask <= MASK_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE:  cfg_reg.settle_count        <= cfg_data[CNT_W-1:0];
                CFG_LONG_HOLD: cfg_reg.long_hold_ms        <= cfg_data[HOLD_W-1:0];
                CFG_VLONG:     cfg_reg.very_long_hold_ms   <= cfg_data[HOLD_W-1:0];
                CFG_MIN_SHORT: cfg_reg.min_short_ms        <= cfg_data[HOLD_W-1:0];
                CFG_MASK:      cfg_reg.vlong_as_short_mask <= cfg_data[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

endmodule

/* src/bdpc_mem.sv */
// Per-button state memory: one write port, one registered read port.
// Entry valid bits clear at reset so an unwritten entry reads as all zeros.
// Depends on bdpc_pkg.
`timescale 1ns / 1ps

module bdpc_mem #(
    parameter  int NUM_BUTTONS = 2,
    localparam int ADDR_W      = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_en,
    input  logic [ADDR_W-1:0]      rd_addr,
    output bdpc_pkg::btn_entry_t   rd_data,
    input  logic                   wr_en,
    input  logic [ADDR_W-1:0]      wr_addr,
    input  bdpc_pkg::btn_entry_t   wr_data
);
    import bdpc_pkg::*;

    btn_entry_t             mem [NUM_BUTTONS];
    btn_entry_t             rd_data_reg;
    logic [NUM_BUTTONS-1:0] vld_reg;
    logic                   rd_vld_reg;

    // Write the array and register the read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Track which entries hold written data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Present the reset state for entries never written
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* src/button_debounce_press_classifier.sv */
// Button debouncer and press classifier. Takes one pin sample per beat and
// returns at most one short, long or very-long press event per sample, in
// sample order. A sample is accepted every cycle while the output side keeps
// up; its event is loaded into the output register when the update stage advances.
// The path runs through the registered read of the per-button state memory,
// issued at the accepting edge, and the output register that the update stage
// loads while it writes the entry back; a sample of the same button read in
// that same cycle takes the written entry by forwarding. State entries are
// cleared at reset by valid bits, so no clearing pass is needed. Depends on
// bdpc_pkg, bdpc_cfg and bdpc_mem.
`timescale 1ns / 1ps

module button_debounce_press_classifier #(
    parameter int NUM_BUTTONS = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [bdpc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] pin_level, [32:1] now_ms
    input  logic                                s_tuser,   // [0] button
    // Event stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bdpc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [1:0] event_kind
    output logic                                m_tuser,   // [0] event_button
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdpc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bdpc_pkg::*;

    localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    cfg_t              cfg;

    logic              in_button;
    logic              in_pin;
    logic [TIME_W-1:0] in_now;
    logic              in_range;
    logic              s_accept;
    logic              out_free;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    btn_entry_t        rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    btn_entry_t        wr_data;

    logic              s1_valid_reg;
    logic              s1_button_reg;
    logic              s1_pin_reg;
    logic [TIME_W-1:0] s1_now_reg;
    logic              byp_valid_reg;
    btn_entry_t        byp_data_reg;

    btn_entry_t        cur;
    btn_entry_t        nxt;
    logic              raw;
    logic [TIME_W-1:0] held;
    logic              hit_long;
    logic              hit_vlong;
    logic              hit_short;
    logic              do_hold;
    logic              s1_fire;
    event_kind_t       s1_kind;

    logic              m_valid_reg;
    event_kind_t       m_kind_reg;
    logic              m_button_reg;

    bdpc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bdpc_mem #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Unpack the sample beat
    assign in_button = s_tuser;
    assign in_pin    = s_tdata[0];
    assign in_now    = s_tdata[TIME_W:1];
    assign in_range  = int'(in_button) < NUM_BUTTONS;

    // Handshake: advance the update stage whenever the output register frees
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // Issue the state read for an in-range sample
    assign rd_en   = s_accept && in_range;
    assign rd_addr = ADDR_W'(in_button);

    // Write back the updated entry as the stage advances
    assign wr_en   = s1_valid_reg && out_free;
    assign wr_addr = ADDR_W'(s1_button_reg);
    assign wr_data = nxt;

    // Update stage control; flag a same-button read that misses the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg  <= rd_en;
            byp_valid_reg <= rd_en && wr_en && (wr_addr == rd_addr);
        end
    end

    // Update stage payload and forwarded entry
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_button_reg <= in_button;
            s1_pin_reg    <= in_pin;
            s1_now_reg    <= in_now;
        end
        if (wr_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    // Pick the freshest copy of the entry
    assign cur = byp_valid_reg ? byp_data_reg : rd_data;

    // Hold time and threshold compares
    assign raw       = ~s1_pin_reg;
    assign held      = s1_now_reg - cur.press_time;
    assign hit_long  = held >= TIME_W'(cfg.long_hold_ms);
    assign hit_vlong = held >= TIME_W'(cfg.very_long_hold_ms);
    assign hit_short = held >= TIME_W'(cfg.min_short_ms);

    // Debounce, press tracking and event selection
    always_comb
    begin
        nxt     = cur;
        s1_fire = 1'b0;
        s1_kind = EV_SHORT;
        do_hold = 1'b0;

        if (raw == cur.previous_raw)
        begin
            if (cur.run_count < cfg.settle_count)
            begin
                nxt.run_count = cur.run_count + 1'b1;
            end
        end
        else
        begin
            nxt.run_count = '0;
        end
        nxt.previous_raw = raw;

        if (nxt.run_count < cfg.settle_count)
        begin
            // Level still settling: keep checking the hold of a press
            do_hold = cur.stable_pressed;
        end
        else
        begin
            nxt.stable_pressed = raw;
            if (raw && !cur.stable_pressed)
            begin
                nxt.press_time     = s1_now_reg;
                nxt.long_done      = 1'b0;
                nxt.very_long_done = 1'b0;
            end
            else if (raw && cur.stable_pressed)
            begin
                do_hold = 1'b1;
            end
            else if (!raw && cur.stable_pressed)
            begin
                if (!cur.long_done && !cur.very_long_done && hit_short)
                begin
                    s1_fire = 1'b1;
                    s1_kind = EV_SHORT;
                end
            end
        end

        // Fire very-long first, else long, each once per press
        if (do_hold)
        begin
            if (hit_vlong && !cur.very_long_done)
            begin
                nxt.very_long_done = 1'b1;
                s1_fire            = 1'b1;
                s1_kind            = cfg.vlong_as_short_mask[s1_button_reg] ? EV_SHORT
                                                                            : EV_VLONG;
            end
            else if (hit_long && !cur.long_done)
            begin
                nxt.long_done = 1'b1;
                s1_fire       = 1'b1;
                s1_kind       = EV_LONG;
            end
        end
    end

    // Output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_valid_reg <= s1_valid_reg && s1_fire;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && s1_fire)
        begin
            m_kind_reg   <= s1_kind;
            m_button_reg <= s1_button_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-KIND_W){1'b0}}, m_kind_reg};
    assign m_tuser  = m_button_reg;

    // A forwarded entry always belongs to the item in the update stage
    a_byp_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> s1_valid_reg)
        else $error("forwarded entry without an item in the update stage");

    // A stalled update stage keeps its item
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s_tready |=> s1_valid_reg)
        else $error("update stage lost its item while stalled");

    // A long event marks the press as long-fired in the written entry
    a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && s1_fire && (s1_kind == EV_LONG) |-> wr_data.long_done)
        else $error("long event without long flag written back");

    // A delivered event comes from a fired item in the previous cycle
    a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_valid_reg && s1_fire))
        else $error("event appeared without a fired item");

endmodule

/* sim/bdpc_tb_pkg.sv */
// Checking side of the button press classifier bench: a scoreboard class
// that predicts press events from accepted samples and compares results.
// Depends on bdpc_pkg for the configuration, state entry and event codes.
`timescale 1ns / 1ps

package bdpc_tb_pkg;

    import bdpc_pkg::*;

    typedef struct {
        event_kind_t kind;
        logic        button;
    } press_event_t;

    class press_scoreboard;

        cfg_t         cfg;
        btn_entry_t   st [2];
        press_event_t pending_events [$];
        int           mismatches;
        int           samples_seen;
        int           events_checked;

        function new();
            cfg.settle_count        = DEBOUNCE_RST;
            cfg.long_hold_ms        = LONG_RST;
            cfg.very_long_hold_ms   = VLONG_RST;
            cfg.min_short_ms        = MIN_SHORT_RST;
            cfg.vlong_as_short_mask = MASK_RST;
            st[0] = '0;
            st[1] = '0;
            mismatches     = 0;
            samples_seen   = 0;
            events_checked = 0;
        endfunction

        // Mirror one register write; unknown indexes leave everything alone
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DEBOUNCE:  cfg.settle_count        = data[CNT_W-1:0];
                CFG_LONG_HOLD: cfg.long_hold_ms        = data[HOLD_W-1:0];
                CFG_VLONG:     cfg.very_long_hold_ms   = data[HOLD_W-1:0];
                CFG_MIN_SHORT: cfg.min_short_ms        = data[HOLD_W-1:0];
                CFG_MASK:      cfg.vlong_as_short_mask = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        // Hold check while pressed: very-long first, then long, each once per press
        function bit hold_fires(int b, logic [TIME_W-1:0] now, output event_kind_t kind);
            logic [TIME_W-1:0] held;
            held = now - st[b].press_time;
            kind = EV_SHORT;
            if (held >= {16'd0, cfg.very_long_hold_ms} && !st[b].very_long_done)
            begin
                st[b].very_long_done = 1'b1;
                kind = cfg.vlong_as_short_mask[b] ? EV_SHORT : EV_VLONG;
                return 1'b1;
            end
            if (held >= {16'd0, cfg.long_hold_ms} && !st[b].long_done)
            begin
                st[b].long_done = 1'b1;
                kind = EV_LONG;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Advance the debouncer of one button and queue the event it causes
        function void note_sample(logic button, logic pin, logic [TIME_W-1:0] now);
            int                b;
            logic              raw;
            logic              prev;
            logic [TIME_W-1:0] held;
            bit                fired;
            event_kind_t       kind;
            press_event_t      ev;
            b     = button;
            raw   = ~pin;
            fired = 1'b0;
            kind  = EV_SHORT;
            samples_seen++;

            if (raw == st[b].previous_raw)
            begin
                if (st[b].run_count < cfg.settle_count)
                    st[b].run_count = st[b].run_count + 1'b1;
            end
            else
                st[b].run_count = '0;
            st[b].previous_raw = raw;

            if (st[b].run_count < cfg.settle_count)
            begin
                // level still settling: the hold check keeps running
                if (st[b].stable_pressed)
                    fired = hold_fires(b, now, kind);
            end
            else
            begin
                prev = st[b].stable_pressed;
                st[b].stable_pressed = raw;
                if (raw && !prev)
                begin
                    st[b].press_time     = now;
                    st[b].long_done      = 1'b0;
                    st[b].very_long_done = 1'b0;
                end
                else if (raw && prev)
                    fired = hold_fires(b, now, kind);
                else if (!raw && prev)
                begin
                    held = now - st[b].press_time;
                    if (!st[b].long_done && !st[b].very_long_done &&
                        held >= {16'd0, cfg.min_short_ms})
                    begin
                        kind  = EV_SHORT;
                        fired = 1'b1;
                    end
                end
            end

            if (fired)
            begin
                ev.kind   = kind;
                ev.button = button;
                pending_events.push_back(ev);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one event beat with the oldest prediction
        task check_event(logic [KIND_W-1:0] kind, logic button);
            press_event_t want;
            if (pending_events.size() == 0)
            begin
                report_mismatch($sformatf("event kind %0d button %0d with none predicted",
                                          kind, button));
                return;
            end
            want = pending_events.pop_front();
            events_checked++;
            if (kind !== KIND_W'(want.kind))
                report_mismatch($sformatf("event_kind %0d, predicted %0d (button %0d)",
                                          kind, want.kind, want.button));
            if (button !== want.button)
                report_mismatch($sformatf("event_button %0d, predicted %0d",
                                          button, want.button));
        endtask

    endclass

endpackage

/* sim/tb_top.sv */
// Top of the button press classifier bench: clock, reset, stream and
// configuration drivers, event monitor, stall watchdog and test sequence.
// Depends on bdpc_pkg, bdpc_tb_pkg and the button_debounce_press_classifier RTL.
`timescale 1ns / 1ps

module tb_top;

    import bdpc_pkg::*;
    import bdpc_tb_pkg::*;

    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 275;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_OFF       = 300;
    localparam int BURST_ITEMS    = 40;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    press_scoreboard sb;

    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_req_seq;
    int          hold_seen;
    int          rx_hold_left;
    int          stall_cycles;
    int          items_sent;
    int          settings_used;
    logic [31:0] t_now;
    logic        last_pin [2];

    button_debounce_press_classifier #(
        .NUM_BUTTONS (2)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Receiver: long hold-off on request, otherwise random back-pressure
    always @(negedge clk)
    begin
        if (hold_req_seq != hold_seen)
        begin
            hold_seen    = hold_req_seq;
            rx_hold_left = HOLD_OFF;
        end
        if (rx_hold_left > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check every accepted event beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_event(m_tdata[KIND_W-1:0], m_tuser);
    end

    // End the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no beat for %0d cycles", $time, stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one sample beat, with random gaps in front; called at a falling edge
    task drive_sample(logic b, logic pin, logic [31:0] now);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, now, pin};
        s_tuser  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(b, pin, now);
        last_pin[b] = pin;
        items_sent++;
        @(negedge clk);
    endtask

    // Advance time and send a sample, sometimes with one of the other button first
    task send_step(logic b, logic pin, int unsigned dt);
        t_now = t_now + dt;
        if ($urandom_range(99) < 15)
            drive_sample(~b, last_pin[~b], t_now);
        drive_sample(b, pin, t_now);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Write every register, plus one write to an unused index
    task load_settings(logic [3:0] dc, logic [15:0] lh, logic [15:0] vl,
                       logic [15:0] ms, logic [1:0] mk);
        write_reg(CFG_IDX_W'(CFG_UNUSED_LO + $urandom_range(2)), CFG_DATA_W'($urandom));
        write_reg(CFG_DEBOUNCE, {12'd0, dc});
        write_reg(CFG_LONG_HOLD, lh);
        write_reg(CFG_VLONG, vl);
        write_reg(CFG_MIN_SHORT, ms);
        write_reg(CFG_MASK, {14'd0, mk});
        cfg_valid <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    // Wait until every predicted event is out and the pipeline is empty
    task drain_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One well-formed press: bounce, settle, hold, optional glitches, release
    task run_press(logic b);
        int unsigned dc;
        int unsigned lh;
        int unsigned vl;
        int unsigned ms;
        int unsigned hold;
        int unsigned k;
        int unsigned step;
        int unsigned i;
        dc = sb.cfg.settle_count;
        lh = sb.cfg.long_hold_ms;
        vl = sb.cfg.very_long_hold_ms;
        ms = sb.cfg.min_short_ms;
        case ($urandom_range(3))
            0: hold = $urandom_range(2 * ms + 4);
            1: hold = $urandom_range(lh + lh / 4 + 8, lh / 2);
            2: hold = $urandom_range(vl + vl / 4 + 8, vl / 2);
            default: hold = $urandom_range(70000);
        endcase
        for (i = 0; i < $urandom_range(3); i++)
            send_step(b, i[0], $urandom_range(2));
        for (i = 0; i <= dc; i++)
            send_step(b, 1'b0, $urandom_range(2));
        k    = $urandom_range(8, 1);
        step = hold / k;
        for (i = 0; i < k; i++)
        begin
            if ($urandom_range(99) < 12)
                send_step(b, 1'b1, 0);
            send_step(b, 1'b0, step + $urandom_range(1));
        end
        for (i = 0; i < $urandom_range(2); i++)
            send_step(b, ~i[0], $urandom_range(2));
        for (i = 0; i <= dc; i++)
            send_step(b, 1'b1, $urandom_range(2));
    endtask

    initial
    begin
        int p;
        int i;
        int start;
        logic b;

        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_DEBOUNCE;
        cfg_data     = '0;
        tx_idle_pct  = 35;
        rx_idle_pct  = 67;
        hold_req_seq = 0;
        hold_seen    = 0;
        rx_hold_left = 0;
        stall_cycles = 0;
        items_sent   = 0;
        settings_used = 0;
        t_now        = '0;
        last_pin[0]  = 1'b1;
        last_pin[1]  = 1'b1;
        sb = new();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: wrap of the hold time, long then very-long, very-long as short
        // followed by a later long, a short press and one below the minimum
        load_settings(4'd1, 16'd100, 16'd200, 16'd50, 2'b10);
        drive_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
        drive_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
        drive_sample(1'b0, 1'b0, 32'h0000_0064);
        drive_sample(1'b0, 1'b0, 32'h0000_00C8);
        drive_sample(1'b0, 1'b1, 32'h0000_00D0);
        drive_sample(1'b0, 1'b1, 32'h0000_00D8);
        drive_sample(1'b1, 1'b0, 32'h0000_1000);
        drive_sample(1'b1, 1'b0, 32'h0000_1000);
        drive_sample(1'b1, 1'b0, 32'h0000_10FA);
        drive_sample(1'b1, 1'b0, 32'h0000_1104);
        drive_sample(1'b1, 1'b1, 32'h0000_1110);
        drive_sample(1'b1, 1'b1, 32'h0000_1110);
        drive_sample(1'b0, 1'b0, 32'h0000_2000);
        drive_sample(1'b0, 1'b0, 32'h0000_2000);
        drive_sample(1'b0, 1'b1, 32'h0000_203C);
        drive_sample(1'b0, 1'b1, 32'h0000_203C);
        drive_sample(1'b1, 1'b0, 32'h0000_3000);
        drive_sample(1'b1, 1'b0, 32'h0000_3000);
        drive_sample(1'b1, 1'b1, 32'h0000_300A);
        drive_sample(1'b1, 1'b1, 32'h0000_300A);

        // Random phases, each under its own register setting
        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p < 2)
            begin
                tx_idle_pct = 35;
                rx_idle_pct = 67;
            end
            else if (p < 4)
            begin
                tx_idle_pct = 67;
                rx_idle_pct = 35;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            drain_block();

            if (p == 4)
            begin
                // Toggle a pin with zero debounce while the receiver holds off
                load_settings(4'd0, 16'hFFFF, 16'hFFFF, 16'd0, 2'b00);
                hold_req_seq = hold_req_seq + 1;
                b = 1'($urandom_range(1));
                for (i = 0; i < BURST_ITEMS; i++)
                begin
                    t_now = t_now + 1;
                    drive_sample(b, ~last_pin[b], t_now);
                end
                drain_block();
            end

            case (p)
                0: load_settings(DEBOUNCE_RST, LONG_RST, VLONG_RST, MIN_SHORT_RST, MASK_RST);
                1: load_settings(4'd0, 16'd0, 16'hFFFF, 16'd0, 2'b00);
                2: load_settings(4'd15, 16'hFFFF, 16'd0, 16'hFFFF, 2'b11);
                5: load_settings(4'd1, 16'd1, 16'd2, 16'd1, 2'b01);
                default: load_settings(CNT_W'($urandom_range(4, 1)),
                                       HOLD_W'($urandom_range(300, 20)),
                                       HOLD_W'($urandom_range(400, 20)),
                                       HOLD_W'($urandom_range(60)),
                                       MASK_W'($urandom_range(3)));
            endcase

            if ($urandom_range(3) == 0)
                t_now = 32'hFFFF_FF00 + $urandom_range(255);
            else
                t_now = $urandom;

            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    // noise: unrelated samples with arbitrary timestamps
                    for (i = 0; i < $urandom_range(4, 1); i++)
                        drive_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                     $urandom);
                end
                else
                    run_press(1'($urandom_range(1)));
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d samples under %0d register settings, %0d events checked",
                 sb.samples_seen, settings_used, sb.events_checked);
        $display("with sender and receiver gaps, one long receiver hold-off, and %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
